/* src/bfr_pkg.sv */
`timescale 1ns / 1ps

package bfr_pkg;

    localparam int IN_WIDTH_DEF  = 64;
    localparam int OUT_WIDTH_DEF = 32;
    localparam int CFG_W         = 31;
    localparam logic [CFG_W-1:0] MAX_TERM_RESET = 31'd30000;

    // shared unit operation
    typedef enum logic
    {
        OP_DIV,
        OP_MUL
    } op_t;

    // sequencer states
    typedef enum logic [4:0]
    {
        S_IDLE,
        S_GCD,
        S_RED_N,
        S_RED_D,
        S_FIT,
        S_CF_DIV,
        S_YP,
        S_YQ,
        S_CHECK,
        S_NP,
        S_NQ,
        S_F,
        S_L,
        S_R,
        S_SP,
        S_OUT
    } state_t;

    typedef struct packed
    {
        logic start;
        op_t  op;
    } unit_req_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

/* src/bfr_unit.sv */
`timescale 1ns / 1ps

// Shared shift/add unit: restoring divide or shift-add multiply, one bit a cycle.
// Divide: res_lo = quotient, res_hi = remainder. Multiply: {res_hi, res_lo} = product.
module bfr_unit
    import bfr_pkg::*;
#(
    parameter int UW = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  unit_req_t     req,
    input  logic [UW-1:0] opa,
    input  logic [UW-1:0] opb,
    output unit_stat_t    stat,
    output logic [UW-1:0] res_hi,
    output logic [UW-1:0] res_lo
);

    localparam int CW = $clog2(UW + 1);

    logic [UW-1:0] hi_reg, hi_next;
    logic [UW-1:0] lo_reg, lo_next;
    logic [UW-1:0] b_reg;
    op_t           op_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic          is_div;
    logic [UW+1:0] ext_b;
    logic [UW+1:0] first;
    logic [UW+1:0] addend;
    logic [UW+1:0] sum;
    logic          ge;

    // one shared adder for both operations
    always_comb
    begin
        is_div = (op_reg == OP_DIV);
        ext_b  = {2'b00, b_reg};
        if (is_div)
        begin
            first  = {1'b0, hi_reg, lo_reg[UW-1]};
            addend = ~ext_b;
        end
        else
        begin
            first  = {2'b00, hi_reg};
            addend = lo_reg[0] ? ext_b : '0;
        end
        sum = first + addend + {{(UW+1){1'b0}}, is_div};
        ge  = ~sum[UW+1];
    end

    always_comb
    begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            hi_next   = '0;
            lo_next   = opa;
            cnt_next  = CW'(UW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (is_div)
            begin
                hi_next = ge ? sum[UW-1:0] : first[UW-1:0];
                lo_next = {lo_reg[UW-2:0], ge};
            end
            else
            begin
                hi_next = sum[UW:1];
                lo_next = {sum[0], lo_reg[UW-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operands and datapath
    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        if (req.start)
        begin
            b_reg  <= opb;
            op_reg <= req.op;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res_hi    = hi_reg;
    assign res_lo    = lo_reg;

endmodule

/* src/bfr_ctrl.sv */
`timescale 1ns / 1ps

// Sequencer: Euclid gcd, reduction, convergent walk, semiconvergent check.
module bfr_ctrl
    import bfr_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int OUT_WIDTH = OUT_WIDTH_DEF,
    parameter int UW        = (IN_WIDTH > OUT_WIDTH + 1) ? IN_WIDTH : OUT_WIDTH + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [IN_WIDTH-1:0]  in_num,
    input  logic [IN_WIDTH-1:0]  in_den,
    input  logic [CFG_W-1:0]     max_term,
    input  logic                 out_ready,
    output logic                 res_fire,
    output logic [OUT_WIDTH-1:0] res_num,
    output logic [OUT_WIDTH-2:0] res_den,
    output logic                 res_exact,
    output unit_req_t            req,
    input  unit_stat_t           stat,
    output logic [UW-1:0]        opa,
    output logic [UW-1:0]        opb,
    input  logic [UW-1:0]        res_hi,
    input  logic [UW-1:0]        res_lo
);

    localparam int TW = OUT_WIDTH - 1;
    localparam logic [CFG_W-1:0] OUT_LIM = CFG_W'({TW{1'b1}});

    state_t          state_reg, state_next;
    logic            issued_reg, issued_next;
    logic [UW-1:0]   a_reg, a_next, b_reg, b_next;
    logic [UW-1:0]   num_reg, num_next, den_reg, den_next;
    logic [UW-1:0]   x_reg, x_next, rem_reg, rem_next;
    logic [UW-1:0]   xs_reg, xs_next, f_reg, f_next;
    logic [2*UW-1:0] lp_reg, lp_next;
    logic [TW-1:0]   p0_reg, p0_next, q0_reg, q0_next;
    logic [TW-1:0]   p1_reg, p1_next, q1_reg, q1_next;
    logic [TW-1:0]   yp_reg, yp_next, yq_reg, yq_next;
    logic [TW-1:0]   np_reg, np_next, fq_reg, fq_next;
    logic [TW-1:0]   lim_reg, lim_next;
    logic            pover_reg, pover_next, qover_reg, qover_next;
    logic            sign_reg, sign_next;

    logic            nneg, dneg;
    logic [IN_WIDTH-1:0] nmag, dmag;
    logic [UW-1:0]   limw;
    logic [UW-1:0]   xs_c;
    logic            exceed;

    // input magnitudes
    always_comb
    begin
        nneg = in_num[IN_WIDTH-1];
        dneg = in_den[IN_WIDTH-1];
        nmag = nneg ? (~in_num + 1'b1) : in_num;
        dmag = dneg ? (~in_den + 1'b1) : in_den;
        limw = UW'(lim_reg);
    end

    // overflow test and largest fitting semiconvergent term
    always_comb
    begin
        exceed = pover_reg || qover_reg
              || ((p1_reg != '0) && (x_reg > UW'(yp_reg)))
              || ((q1_reg != '0) && (x_reg > UW'(yq_reg)));
        xs_c = x_reg;
        if (p1_reg != '0)
        begin
            xs_c = UW'(yp_reg);
        end
        if ((q1_reg != '0) && (UW'(yq_reg) < xs_c))
        begin
            xs_c = UW'(yq_reg);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        x_next      = x_reg;
        rem_next    = rem_reg;
        xs_next     = xs_reg;
        f_next      = f_reg;
        lp_next     = lp_reg;
        p0_next     = p0_reg;
        q0_next     = q0_reg;
        p1_next     = p1_reg;
        q1_next     = q1_reg;
        yp_next     = yp_reg;
        yq_next     = yq_reg;
        np_next     = np_reg;
        fq_next     = fq_reg;
        lim_next    = lim_reg;
        pover_next  = pover_reg;
        qover_next  = qover_reg;
        sign_next   = sign_reg;
        req.start   = 1'b0;
        req.op      = OP_DIV;
        opa         = '0;
        opb         = '0;
        res_fire    = 1'b0;
        in_stall    = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    num_next  = UW'(nmag);
                    den_next  = UW'(dmag);
                    a_next    = UW'(nmag);
                    b_next    = UW'(dmag);
                    sign_next = nneg ^ dneg;
                    lim_next  = (max_term > OUT_LIM) ? OUT_LIM[TW-1:0] : max_term[TW-1:0];
                    state_next = S_GCD;
                end
            end

            // Euclid: a, b <- b, a mod b
            S_GCD:
            begin
                opa = a_reg;
                opb = b_reg;
                if (!issued_reg)
                begin
                    if (b_reg == '0)
                    begin
                        state_next = (a_reg == '0) ? S_FIT : S_RED_N;
                    end
                    else
                    begin
                        req.start   = 1'b1;
                        issued_next = 1'b1;
                    end
                end
                else if (stat.done)
                begin
                    a_next      = b_reg;
                    b_next      = res_hi;
                    issued_next = 1'b0;
                end
            end

            S_RED_N, S_RED_D:
            begin
                opa = (state_reg == S_RED_N) ? num_reg : den_reg;
                opb = a_reg;
                if (!issued_reg)
                begin
                    req.start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (stat.done)
                begin
                    issued_next = 1'b0;
                    if (state_reg == S_RED_N)
                    begin
                        num_next   = res_lo;
                        state_next = S_RED_D;
                    end
                    else
                    begin
                        den_next   = res_lo;
                        state_next = S_FIT;
                    end
                end
            end

            S_FIT:
            begin
                if ((num_reg <= limw) && (den_reg <= limw))
                begin
                    p1_next    = num_reg[TW-1:0];
                    q1_next    = den_reg[TW-1:0];
                    den_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    p0_next    = '0;
                    q0_next    = TW'(1);
                    p1_next    = TW'(1);
                    q1_next    = '0;
                    state_next = (den_reg == '0) ? S_OUT : S_CF_DIV;
                end
            end

            // next continued-fraction term
            S_CF_DIV:
            begin
                opa = num_reg;
                opb = den_reg;
                if (!issued_reg)
                begin
                    req.start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (stat.done)
                begin
                    issued_next = 1'b0;
                    x_next      = res_lo;
                    rem_next    = res_hi;
                    state_next  = S_YP;
                end
            end

            // largest term keeping p (resp. q) within the limit
            S_YP, S_YQ:
            begin
                if (state_reg == S_YP)
                begin
                    opa = UW'(lim_reg - p0_reg);
                    opb = UW'(p1_reg);
                end
                else
                begin
                    opa = UW'(lim_reg - q0_reg);
                    opb = UW'(q1_reg);
                end
                if (!issued_reg)
                begin
                    if (state_reg == S_YP && (p0_reg > lim_reg || p1_reg == '0))
                    begin
                        yp_next    = '0;
                        pover_next = (p0_reg > lim_reg);
                        state_next = S_YQ;
                    end
                    else if (state_reg == S_YQ && (q0_reg > lim_reg || q1_reg == '0))
                    begin
                        yq_next    = '0;
                        qover_next = (q0_reg > lim_reg);
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        req.start   = 1'b1;
                        issued_next = 1'b1;
                    end
                end
                else if (stat.done)
                begin
                    issued_next = 1'b0;
                    if (state_reg == S_YP)
                    begin
                        yp_next    = res_lo[TW-1:0];
                        pover_next = 1'b0;
                        state_next = S_YQ;
                    end
                    else
                    begin
                        yq_next    = res_lo[TW-1:0];
                        qover_next = 1'b0;
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                xs_next    = xs_c;
                state_next = exceed ? S_F : S_NP;
            end

            // regular convergent step
            S_NP, S_NQ:
            begin
                req.op = OP_MUL;
                opa    = x_reg;
                opb    = UW'((state_reg == S_NP) ? p1_reg : q1_reg);
                if (!issued_reg)
                begin
                    req.start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (stat.done)
                begin
                    issued_next = 1'b0;
                    if (state_reg == S_NP)
                    begin
                        np_next    = res_lo[TW-1:0] + p0_reg;
                        state_next = S_NQ;
                    end
                    else
                    begin
                        p0_next    = p1_reg;
                        q0_next    = q1_reg;
                        p1_next    = np_reg;
                        q1_next    = res_lo[TW-1:0] + q0_reg;
                        num_next   = den_reg;
                        den_next   = rem_reg;
                        state_next = (rem_reg == '0) ? S_OUT : S_CF_DIV;
                    end
                end
            end

            // semiconvergent: f = 2*xs*q1 + q0, keep if den*f > num*q1
            S_F, S_L, S_R, S_SP:
            begin
                req.op = OP_MUL;
                case (state_reg)
                    S_F:
                    begin
                        opa = xs_reg;
                        opb = UW'(q1_reg);
                    end
                    S_L:
                    begin
                        opa = den_reg;
                        opb = f_reg;
                    end
                    S_R:
                    begin
                        opa = num_reg;
                        opb = UW'(q1_reg);
                    end
                    default:
                    begin
                        opa = xs_reg;
                        opb = UW'(p1_reg);
                    end
                endcase
                if (!issued_reg)
                begin
                    req.start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (stat.done)
                begin
                    issued_next = 1'b0;
                    case (state_reg)
                        S_F:
                        begin
                            fq_next    = res_lo[TW-1:0];
                            f_next     = {res_lo[UW-2:0], 1'b0} + UW'(q0_reg);
                            state_next = S_L;
                        end
                        S_L:
                        begin
                            lp_next    = {res_hi, res_lo};
                            state_next = S_R;
                        end
                        S_R:
                        begin
                            state_next = (lp_reg > {res_hi, res_lo}) ? S_SP : S_OUT;
                        end
                        default:
                        begin
                            p1_next    = res_lo[TW-1:0] + p0_reg;
                            q1_next    = fq_reg + q0_reg;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_OUT:
            begin
                if (out_ready)
                begin
                    res_fire   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        x_reg     <= x_next;
        rem_reg   <= rem_next;
        xs_reg    <= xs_next;
        f_reg     <= f_next;
        lp_reg    <= lp_next;
        p0_reg    <= p0_next;
        q0_reg    <= q0_next;
        p1_reg    <= p1_next;
        q1_reg    <= q1_next;
        yp_reg    <= yp_next;
        yq_reg    <= yq_next;
        np_reg    <= np_next;
        fq_reg    <= fq_next;
        lim_reg   <= lim_next;
        pover_reg <= pover_next;
        qover_reg <= qover_next;
        sign_reg  <= sign_next;
    end

    // result formatting
    always_comb
    begin
        res_num   = sign_reg ? (OUT_WIDTH'(0) - OUT_WIDTH'(p1_reg)) : OUT_WIDTH'(p1_reg);
        res_den   = q1_reg;
        res_exact = (den_reg == '0);
    end

    // unit is never restarted mid-operation
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !stat.busy)
        else $error("unit started while busy");

    // a completion always belongs to an issued operation
    a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> issued_reg)
        else $error("unit done without pending request");

    // nothing is pending when the sequencer is idle
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!issued_reg && !stat.busy))
        else $error("operation pending in idle");

endmodule

/* src/bounded_fraction_reducer_top.sv */
// Work: one shared bit-serial unit, UW bits wide, runs each divide or multiply
//   (UW = max(IN_WIDTH, OUT_WIDTH+1)); an item costs (Euclid steps + 2) such ops,
//   up to 5 ops and one check state per convergent step, 4 ops for the closing
//   semiconvergent test, plus the fit test and result handoff states.
// Throughput: one item at a time; in_stall is high from acceptance until the edge
//   that loads the output register, which raises out_valid at that same edge.
// Reset: rst_n asynchronous, active low; clears control and sets max_term to 30000.
`timescale 1ns / 1ps

module bounded_fraction_reducer_top
    import bfr_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int OUT_WIDTH = OUT_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_W-1:0]            cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [IN_WIDTH-1:0]  in_num,
    input  logic signed [IN_WIDTH-1:0]  in_den,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [OUT_WIDTH-1:0] out_num,
    output logic [OUT_WIDTH-2:0]        out_den,
    output logic                        exact
);

    localparam int UW = (IN_WIDTH > OUT_WIDTH + 1) ? IN_WIDTH : OUT_WIDTH + 1;

    logic [CFG_W-1:0]     max_term_reg;
    logic                 out_valid_reg;
    logic [OUT_WIDTH-1:0] out_num_reg;
    logic [OUT_WIDTH-2:0] out_den_reg;
    logic                 exact_reg;

    unit_req_t            req;
    unit_stat_t           stat;
    logic [UW-1:0]        opa, opb, res_hi, res_lo;
    logic                 out_ready;
    logic                 res_fire;
    logic [OUT_WIDTH-1:0] res_num;
    logic [OUT_WIDTH-2:0] res_den;
    logic                 res_exact;

    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_term_reg <= MAX_TERM_RESET;
        end
        else if (cfg_we)
        begin
            max_term_reg <= cfg_wdata;
        end
    end

    bfr_ctrl #(
        .IN_WIDTH  (IN_WIDTH),
        .OUT_WIDTH (OUT_WIDTH),
        .UW        (UW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_num    (in_num),
        .in_den    (in_den),
        .max_term  (max_term_reg),
        .out_ready (out_ready),
        .res_fire  (res_fire),
        .res_num   (res_num),
        .res_den   (res_den),
        .res_exact (res_exact),
        .req       (req),
        .stat      (stat),
        .opa       (opa),
        .opb       (opb),
        .res_hi    (res_hi),
        .res_lo    (res_lo)
    );

    bfr_unit #(
        .UW (UW)
    ) u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .opa    (opa),
        .opb    (opb),
        .stat   (stat),
        .res_hi (res_hi),
        .res_lo (res_lo)
    );

    // output register; free when empty or the current beat leaves
    assign out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            out_num_reg <= res_num;
            out_den_reg <= res_den;
            exact_reg   <= res_exact;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_num   = out_num_reg;
    assign out_den   = out_den_reg;
    assign exact     = exact_reg;

endmodule
